[design/dtq_pkg.sv]
// Package for the deadline timer queue: field widths, action and kind codes,
// cell and scan types. No dependencies.
package dtq_pkg;

   localparam int NumTimers = 64;
   localparam int SlotBits  = 6;
   localparam int GenBits   = 16;
   localparam int TimeBits  = 63;
   localparam int PerBits   = 40;
   localparam int CntBits   = 7;

   localparam logic [TimeBits-1:0] TimeMax = {TimeBits{1'b1}};

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_CANCEL = 2'd1,
      ACT_TICK   = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_CANCEL = 2'd1,
      KIND_TICK   = 2'd2
   } kind_type;

   // Command broadcast from the sequencer to every cell at once.
   // Rearm applies to every marked cell at once.
   typedef enum logic [2:0] {
      CMD_IDLE,
      CMD_WRITE,
      CMD_CLEAR,
      CMD_MARK,
      CMD_REARM
   } cell_cmd_type;

   // What a scan looks for: any armed entry, due and not yet reported
   // entries, or the earliest deadline once the current tick is applied.
   typedef enum logic [1:0] {
      SCAN_ALL,
      SCAN_DUE,
      SCAN_NEXT
   } scan_mode_type;

   typedef struct packed {
      cell_cmd_type          cmd;
      logic [SlotBits-1:0]   slot;
      logic [TimeBits-1:0]   deadline;
      logic [PerBits-1:0]    period;
      logic [GenBits-1:0]    generation;
      logic [TimeBits-1:0]   now;
   } cell_ctl_type;

   // Running best along the chain: earliest candidate entry, first free
   // slot and the number of due entries not yet reported.
   typedef struct packed {
      logic                  found;
      logic [TimeBits-1:0]   deadline;
      logic [SlotBits-1:0]   slot;
      logic [GenBits-1:0]    generation;
      logic                  free_found;
      logic [SlotBits-1:0]   free_slot;
      logic [CntBits-1:0]    due_count;
   } scan_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CANCEL,
      ST_SCAN,
      ST_APPLY,
      ST_TICK_NEXT,
      ST_POP,
      ST_EMIT
   } state_type;

endpackage

[design/deadline_timer_queue_unit.sv]
// Top level of the deadline timer queue: a chain of 64 slot cells and the
// sequencer that scans it. Uses dtq_pkg and dtq_cell.
//
//  channel | dir | fields
//  req_    | in  | tdata: action, time_value, repeat_interval, slot, generation
//  rsp_    | out | tdata: see port; tlast: last result of the request
//
// A scan crosses the chain one cell per cycle.
// Add: scan, apply, result. Cancel: one check step, then as add. Tick: one
// scan for the next deadline, then the result if nothing is due; else, for
// each due timer, one scan, pop and result.
// Reset clears the armed bits, tick marks and generation counter.
// A stalled rsp_ holds the sequencer; req_ is taken only when idle.
module deadline_timer_queue_unit
   import dtq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [1:0] action, [64:2] time_value, [104:65] repeat_interval,
   // [110:105] handle_slot, [126:111] handle_generation, [127] zero
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [1:0] kind, [2] ok, [8:3] slot, [24:9] generation, [25] earliest_changed,
   // [88:26] next_deadline, [89] deadline_valid, [95:90] zero
   output logic [95:0]  rsp_tdata,
   output logic         rsp_tlast
);

   state_type state_ff, state_in;
   cell_ctl_type ctl;
   scan_type chain [NumTimers+1];
   logic [NumTimers-1:0] armed_v;
   logic [GenBits-1:0] gens [NumTimers];
   logic [CntBits:0] step_ff, step_in;
   logic [CntBits-1:0] pops_ff, pops_in;
   logic [CntBits-1:0] dcnt_ff, dcnt_in;
   scan_mode_type mode_ff, mode_in;
   logic [1:0] act_ff;
   logic [TimeBits-1:0] tv_ff;
   logic [PerBits-1:0] per_ff;
   logic [SlotBits-1:0] hs_ff;
   logic [GenBits-1:0] hg_ff;
   logic [GenBits-1:0] gcnt_ff, gcnt_in;
   logic req_take;
   scan_type res;
   // pending result
   logic [1:0] r_kind_ff, r_kind_in;
   logic r_ok_ff, r_ok_in, r_ec_ff, r_ec_in, r_last_ff, r_last_in;
   logic [SlotBits-1:0] r_slot_ff, r_slot_in;
   logic [GenBits-1:0] r_gen_ff, r_gen_in;
   logic r_dv_ff, r_dv_in;
   logic [TimeBits-1:0] r_nd_ff, r_nd_in;
   logic cancel_hit;

   assign chain[0] = '0;
   assign res      = chain[NumTimers];
   assign req_take = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // Result channel
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = {6'd0, r_dv_ff, r_nd_ff, r_ec_ff, r_gen_ff, r_slot_ff,
                        r_ok_ff, r_kind_ff};
   assign rsp_tlast  = r_last_ff;

   for (genvar i = 0; i < NumTimers; i++) begin : g_cell
      dtq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .my_slot    (SlotBits'(i)),
         .ctl        (ctl),
         .mode       (mode_ff),
         .due_time   (tv_ff),
         .scan_in    (chain[i]),
         .scan_ff    (chain[i+1]),
         .armed      (armed_v[i]),
         .generation (gens[i])
      );
   end

   assign cancel_hit = armed_v[hs_ff] && (gens[hs_ff] == hg_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         gcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         gcnt_ff  <= gcnt_in;
      end
      step_ff <= step_in;
      pops_ff <= pops_in;
      dcnt_ff <= dcnt_in;
      mode_ff <= mode_in;
      r_kind_ff <= r_kind_in; r_ok_ff <= r_ok_in; r_ec_ff <= r_ec_in;
      r_last_ff <= r_last_in; r_slot_ff <= r_slot_in; r_gen_ff <= r_gen_in;
      r_dv_ff <= r_dv_in; r_nd_ff <= r_nd_in;
      if (req_take) begin
         act_ff <= req_tdata[1:0];
         tv_ff  <= req_tdata[64:2];
         per_ff <= req_tdata[104:65];
         hs_ff  <= req_tdata[110:105];
         hg_ff  <= req_tdata[126:111];
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff; step_in = step_ff; pops_in = pops_ff;
      dcnt_in = dcnt_ff; mode_in = mode_ff; gcnt_in = gcnt_ff;
      r_kind_in = r_kind_ff; r_ok_in = r_ok_ff; r_ec_in = r_ec_ff;
      r_last_in = r_last_ff; r_slot_in = r_slot_ff; r_gen_in = r_gen_ff;
      r_dv_in = r_dv_ff; r_nd_in = r_nd_ff;
      ctl = '0; ctl.cmd = CMD_IDLE; ctl.now = tv_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               step_in = '0; pops_in = '0;
               case (req_tdata[1:0])
                  ACT_ADD: begin
                     mode_in = SCAN_ALL; state_in = ST_SCAN;
                  end
                  ACT_CANCEL: state_in = ST_CANCEL;
                  ACT_TICK: begin
                     mode_in = SCAN_NEXT; state_in = ST_SCAN;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CANCEL: begin
            // remove first, then scan for the next deadline
            r_kind_in = KIND_CANCEL; r_ok_in = cancel_hit; r_ec_in = 1'b0;
            r_slot_in = hs_ff; r_gen_in = hg_ff; r_last_in = 1'b1;
            if (cancel_hit) begin
               ctl.cmd = CMD_CLEAR; ctl.slot = hs_ff;
            end
            mode_in = SCAN_ALL; step_in = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == (CntBits+1)'(NumTimers)) begin
               step_in = '0;
               case (mode_ff)
                  SCAN_NEXT: state_in = ST_TICK_NEXT;
                  SCAN_DUE:  state_in = ST_POP;
                  default:   state_in = ST_APPLY;
               endcase
            end
         end
         ST_APPLY: begin
            r_last_in = 1'b1;
            if (act_ff == ACT_ADD) begin
               // res holds the pre-change earliest and first free slot
               r_kind_in = KIND_ADD; r_ok_in = res.free_found;
               r_slot_in = res.free_found ? res.free_slot : '0;
               r_gen_in = res.free_found ? gcnt_ff : '0;
               r_ec_in = res.free_found && (!res.found || tv_ff < res.deadline);
               if (res.free_found) begin
                  ctl.cmd = CMD_WRITE; ctl.slot = res.free_slot;
                  ctl.deadline = tv_ff; ctl.period = per_ff;
                  ctl.generation = gcnt_ff;
                  gcnt_in = gcnt_ff + 1'b1;
                  r_dv_in = 1'b1;
                  r_nd_in = (!res.found || tv_ff < res.deadline) ? tv_ff : res.deadline;
               end else begin
                  r_dv_in = res.found;
                  r_nd_in = res.found ? res.deadline : '0;
               end
            end else begin
               r_dv_in = res.found;
               r_nd_in = res.found ? res.deadline : '0;
            end
            state_in = ST_EMIT;
         end
         ST_TICK_NEXT: begin
            // res holds the earliest deadline once the tick is applied
            r_dv_in = res.found; r_nd_in = res.found ? res.deadline : '0;
            dcnt_in = res.due_count; pops_in = '0;
            r_kind_in = KIND_TICK; r_ec_in = 1'b0;
            if (res.due_count == '0) begin
               r_ok_in = 1'b0; r_slot_in = '0; r_gen_in = '0; r_last_in = 1'b1;
               state_in = ST_EMIT;
            end else begin
               mode_in = SCAN_DUE; step_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_POP: begin
            // report the earliest unreported due timer and mark it
            r_kind_in = KIND_TICK; r_ok_in = 1'b1; r_ec_in = 1'b0;
            r_slot_in = res.slot; r_gen_in = res.generation;
            r_last_in = (CntBits'(pops_ff + 1'b1) == dcnt_ff);
            ctl.cmd = CMD_MARK; ctl.slot = res.slot;
            pops_in = pops_ff + 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               if (r_kind_ff == KIND_TICK && !r_last_ff) begin
                  step_in = '0;
                  state_in = ST_SCAN;
               end else begin
                  if (r_kind_ff == KIND_TICK) ctl.cmd = CMD_REARM;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast));
   // Request and result never in flight together
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid));
   // A pop scan always finds a due timer
   a_pop_found: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP |-> res.found);
   a_state_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown(state_ff));

endmodule

[design/dtq_cell.sv]
// One timer slot cell: holds armed bit, deadline, period and generation, and
// forwards a scan record to its neighbor in every cycle. Uses dtq_pkg.
module dtq_cell
   import dtq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [SlotBits-1:0] my_slot,
   input  cell_ctl_type        ctl,
   input  scan_mode_type       mode,
   input  logic [TimeBits-1:0] due_time,
   input  scan_type            scan_in,
   output scan_type            scan_ff,
   output logic                armed,
   output logic [GenBits-1:0]  generation
);

   logic                armed_ff, armed_in;
   logic                mark_ff, mark_in;
   logic [TimeBits-1:0] deadline_ff, deadline_in;
   logic [PerBits-1:0]  period_ff, period_in;
   logic [GenBits-1:0]  gen_ff, gen_in;
   scan_type            scan_in_next;
   logic [TimeBits:0]   rearm_sum;
   logic [TimeBits-1:0] rearm_dl, cand_dl;
   logic                hit, mine, cand, due;

   assign armed      = armed_ff;
   assign generation = gen_ff;
   assign mine       = (ctl.slot == my_slot);
   assign rearm_sum  = {1'b0, ctl.now} + {{(TimeBits+1-PerBits){1'b0}}, period_ff};
   assign rearm_dl   = rearm_sum[TimeBits] ? TimeMax : rearm_sum[TimeBits-1:0];
   assign due        = armed_ff && (deadline_ff <= due_time);

   // Slot update on a broadcast command
   always_comb begin
      armed_in    = armed_ff;
      mark_in     = mark_ff;
      deadline_in = deadline_ff;
      period_in   = period_ff;
      gen_in      = gen_ff;
      case (ctl.cmd)
         CMD_WRITE: begin
            if (mine) begin
               armed_in    = 1'b1;
               deadline_in = ctl.deadline;
               period_in   = ctl.period;
               gen_in      = ctl.generation;
            end
         end
         CMD_CLEAR: begin
            if (mine) armed_in = 1'b0;
         end
         CMD_MARK: begin
            if (mine) mark_in = 1'b1;
         end
         CMD_REARM: begin
            if (mark_ff) begin
               mark_in = 1'b0;
               if (period_ff == '0) begin
                  armed_in = 1'b0;
               end else begin
                  deadline_in = rearm_dl;
               end
            end
         end
         default: ;
      endcase
   end

   // Compare against the running best; strict less keeps lower slot on ties
   always_comb begin
      case (mode)
         SCAN_DUE: begin
            cand    = due && !mark_ff;
            cand_dl = deadline_ff;
         end
         SCAN_NEXT: begin
            cand    = armed_ff && !(due && period_ff == '0);
            cand_dl = due ? rearm_dl : deadline_ff;
         end
         default: begin
            cand    = armed_ff;
            cand_dl = deadline_ff;
         end
      endcase
      hit = cand && (!scan_in.found || cand_dl < scan_in.deadline);
      scan_in_next = scan_in;
      if (hit) begin
         scan_in_next.found      = 1'b1;
         scan_in_next.deadline   = cand_dl;
         scan_in_next.slot       = my_slot;
         scan_in_next.generation = gen_ff;
      end
      if (!armed_ff && !scan_in.free_found) begin
         scan_in_next.free_found = 1'b1;
         scan_in_next.free_slot  = my_slot;
      end
      if (due && !mark_ff) scan_in_next.due_count = scan_in.due_count + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         mark_ff  <= 1'b0;
      end else begin
         armed_ff <= armed_in;
         mark_ff  <= mark_in;
      end
      deadline_ff <= deadline_in;
      period_ff   <= period_in;
      gen_ff      <= gen_in;
      scan_ff     <= scan_in_next;
   end

endmodule
